/* sv/lps_pkg.sv */
// Shared constants and payload types for the linear prime sieve.
// No dependencies; compiled first.
package lps_pkg;

    localparam int unsigned MAX_N_DEF            = 524288;
    localparam int unsigned PRIME_LIST_DEPTH_DEF = 65536;

    localparam int unsigned NUM_W   = 19;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned TOT_W   = 22;

    localparam logic [NUM_W-1:0] LIMIT_RESET = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [TOT_W-1:0] TOTAL_MAX   = '1;

    typedef struct packed {
        logic restart;
    } t_in_item;

    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic [NUM_W-1:0] smallest_factor;
        logic             is_prime;
        logic [CNT_W-1:0] distinct_factors;
        logic [TOT_W-1:0] running_total;
        logic             past_limit;
    } t_out_item;

endpackage

/* sv/lps_stream_if.sv */
// Valid/ready stream channel carrying one payload per transaction.
// Payload type is given by the instantiating level (types from lps_pkg).
interface lps_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/lps_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lps_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/linear_prime_sieve.sv */
// Linear (Euler) sieve, one number per transaction. Result registered after the table
// lookup (the check alone when past the limit); a restart runs the clear first, and a
// busy output holds it in place. Each listed prime visited by the marking walk goes
// through the prime-list read, the registered multiply and the table write; the next
// transaction is accepted once the walk ends. Reset: synchronous; a clearing pass zeroes
// the table first. A restart clears up to the highest entry written, then processes 2.
module linear_prime_sieve #(
    parameter int unsigned MAX_N            = lps_pkg::MAX_N_DEF,
    parameter int unsigned PRIME_LIST_DEPTH = lps_pkg::PRIME_LIST_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lps_pkg::NUM_W-1:0] i_cfg_wdata,
    lps_stream_if.sink                i_in,
    lps_stream_if.source              o_out
);
    import lps_pkg::*;

    localparam int unsigned AW     = $clog2(MAX_N);
    localparam int unsigned PW     = $clog2(PRIME_LIST_DEPTH);
    localparam int unsigned TW     = NUM_W + CNT_W;
    localparam int unsigned PROD_W = 2 * NUM_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_LOOK, S_RESULT, S_PREAD, S_PMUL, S_PWRITE
    } t_state;

    t_state              r_state;
    logic                r_go;
    logic [AW:0]         r_clr;
    logic [AW:0]         r_high;
    logic [NUM_W-1:0]    r_limit;
    logic [NUM_W:0]      r_cur;
    logic [PW:0]         r_pcount;
    logic [PW:0]         r_k;
    logic [TOT_W-1:0]    r_total;
    logic [NUM_W-1:0]    r_spf;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_prime;
    logic                r_past;
    logic [NUM_W-1:0]    r_p;
    logic [PROD_W-1:0]   r_prod;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                tab_we, tab_re;
    logic [AW-1:0]       tab_waddr;
    logic [TW-1:0]       tab_wdata, tab_rdata;
    logic                pl_we, pl_re;
    logic [NUM_W-1:0]    pl_rdata;

    logic [NUM_W-1:0]    w_fac;
    logic [CNT_W-1:0]    w_cnt;
    logic                w_is_new;
    logic [NUM_W-1:0]    w_spf;
    logic [CNT_W-1:0]    w_cnt_use;
    logic [TOT_W:0]      w_sum;
    logic                w_past;
    logic                w_over;
    logic                w_out_free;
    logic [CNT_W-1:0]    w_cnt_inc;
    logic [AW:0]         w_cur_next_hi;
    logic [AW:0]         w_prod_next_hi;

    assign w_fac          = tab_rdata[TW-1:CNT_W];
    assign w_cnt          = tab_rdata[CNT_W-1:0];
    assign w_is_new       = (w_fac == '0);
    assign w_spf          = w_is_new ? r_cur[NUM_W-1:0] : w_fac;
    assign w_cnt_use      = w_is_new ? CNT_W'(1) : w_cnt;
    assign w_sum          = {1'b0, r_total} + (TOT_W+1)'(w_cnt_use);
    assign w_past         = (r_cur > {1'b0, r_limit}) || (32'(r_cur) >= MAX_N);
    assign w_over         = (r_prod > PROD_W'(r_limit)) || (64'(r_prod) >= 64'(MAX_N));
    assign w_out_free     = !r_out_valid || o_out.ready;
    assign w_cnt_inc      = (r_cnt < COUNT_MAX) ? r_cnt + CNT_W'(1) : COUNT_MAX;
    assign w_cur_next_hi  = (AW+1)'(r_cur) + (AW+1)'(1);
    assign w_prod_next_hi = (AW+1)'(r_prod) + (AW+1)'(1);

    always_comb begin
        tab_we    = 1'b0;
        tab_waddr = AW'(r_clr);
        tab_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                tab_we = (r_clr < r_high);
            end
            S_LOOK: begin
                tab_we    = w_is_new;
                tab_waddr = AW'(r_cur);
                tab_wdata = {r_cur[NUM_W-1:0], CNT_W'(1)};
            end
            S_PWRITE: begin
                tab_we    = !w_over;
                tab_waddr = AW'(r_prod);
                tab_wdata = {r_p, (r_p == r_spf) ? r_cnt : w_cnt_inc};
            end
            default: begin
                tab_we = 1'b0;
            end
        endcase
    end

    assign tab_re = (r_state == S_CHECK) && !w_past;
    assign pl_we  = (r_state == S_LOOK) && w_is_new && (32'(r_pcount) < PRIME_LIST_DEPTH);
    assign pl_re  = (r_state == S_PREAD);

    lps_ram #(.WIDTH(TW), .DEPTH(MAX_N)) u_tab (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_re    (tab_re),
        .i_raddr (AW'(r_cur)),
        .o_rdata (tab_rdata)
    );

    lps_ram #(.WIDTH(NUM_W), .DEPTH(PRIME_LIST_DEPTH)) u_plist (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (r_pcount[PW-1:0]),
        .i_wdata (r_cur[NUM_W-1:0]),
        .i_re    (pl_re),
        .i_raddr (r_k[PW-1:0]),
        .o_rdata (pl_rdata)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_go        <= 1'b0;
            r_clr       <= '0;
            r_high      <= (AW+1)'(MAX_N);
            r_limit     <= LIMIT_RESET;
            r_cur       <= (NUM_W+1)'(2);
            r_pcount    <= '0;
            r_k         <= '0;
            r_total     <= '0;
            r_past      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if ((r_state == S_RESULT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_clr < r_high) begin
                        r_clr <= r_clr + (AW+1)'(1);
                    end else begin
                        r_clr   <= '0;
                        r_high  <= '0;
                        r_state <= r_go ? S_CHECK : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.data.restart) begin
                            r_go     <= 1'b1;
                            r_cur    <= (NUM_W+1)'(2);
                            r_pcount <= '0;
                            r_total  <= '0;
                            r_state  <= S_CLEAR;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_go    <= 1'b0;
                    r_past  <= w_past;
                    r_state <= w_past ? S_RESULT : S_LOOK;
                end
                S_LOOK: begin
                    r_spf   <= w_spf;
                    r_cnt   <= w_cnt_use;
                    r_prime <= w_is_new;
                    r_total <= (w_sum > (TOT_W+1)'(TOTAL_MAX)) ? TOTAL_MAX : w_sum[TOT_W-1:0];
                    if (pl_we) begin
                        r_pcount <= r_pcount + (PW+1)'(1);
                    end
                    if (w_is_new && (w_cur_next_hi > r_high)) begin
                        r_high <= w_cur_next_hi;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        r_k <= '0;
                        if (r_past) begin
                            r_out   <= '{default: '0, past_limit: 1'b1};
                            r_state <= S_IDLE;
                        end else begin
                            r_out.number           <= r_cur[NUM_W-1:0];
                            r_out.smallest_factor  <= r_spf;
                            r_out.is_prime         <= r_prime;
                            r_out.distinct_factors <= r_cnt;
                            r_out.running_total    <= r_total;
                            r_out.past_limit       <= 1'b0;
                            if (r_pcount == '0) begin
                                r_cur   <= r_cur + (NUM_W+1)'(1);
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_PREAD;
                            end
                        end
                    end
                end
                S_PREAD: begin
                    r_state <= S_PMUL;
                end
                S_PMUL: begin
                    r_p     <= pl_rdata;
                    r_prod  <= r_cur[NUM_W-1:0] * pl_rdata;
                    r_state <= S_PWRITE;
                end
                S_PWRITE: begin
                    if (w_over || (r_p == r_spf) || (r_k + (PW+1)'(1) >= r_pcount)) begin
                        r_cur   <= r_cur + (NUM_W+1)'(1);
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + (PW+1)'(1);
                        r_state <= S_PREAD;
                    end
                    if (!w_over && (w_prod_next_hi > r_high)) begin
                        r_high <= w_prod_next_hi;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
